// ----- hw/rtl/xoshiro256pp_generator_core_defines.svh -----
// Assertion macros shared by the xoshiro256++ generator RTL.
// Included by the modules that carry concurrent checks; no other dependencies.
`ifndef XOSHIRO256PP_GENERATOR_CORE_DEFINES_SVH
`define XOSHIRO256PP_GENERATOR_CORE_DEFINES_SVH

`ifndef SYNTHESIS
`define XOSHPP_ASSERT(lbl, clk, rstn, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) \
    else $error("xoshpp assertion failed");
`define XOSHPP_ASSERT_NEVER(lbl, clk, rstn, cond) \
  `XOSHPP_ASSERT(lbl, clk, rstn, !(cond))
`else
`define XOSHPP_ASSERT(lbl, clk, rstn, prop)
`define XOSHPP_ASSERT_NEVER(lbl, clk, rstn, cond)
`endif

`endif

// ----- hw/rtl/xoshpp_pkg.sv -----
// Shared types, constants and step functions for the xoshiro256++ generator.
// No dependencies; used by the interfaces, controller, datapath and top level.
package xoshpp_pkg;

  localparam int unsigned WordW     = 64;
  localparam int unsigned HalfW     = 32;
  localparam int unsigned NumWords  = 4;
  localparam int unsigned OpW       = 2;
  localparam int unsigned JumpSteps = 256;
  localparam int unsigned StepW     = $clog2(JumpSteps);
  localparam int unsigned WordIdxW  = $clog2(NumWords);
  localparam int unsigned MulPhaseW = 2;

  typedef logic [WordW-1:0] word_t;
  typedef logic [HalfW-1:0] half_t;
  typedef word_t [NumWords-1:0] gen_state_t;

  typedef enum logic [OpW-1:0] {
    OP_SEED      = 2'd0,
    OP_NEXT      = 2'd1,
    OP_JUMP      = 2'd2,
    OP_LONG_JUMP = 2'd3
  } xoshpp_op_e;

  // Phases of the shared 32x32 multiplier building a 64-bit low product.
  localparam logic [MulPhaseW-1:0] MUL_LL  = 2'd0;
  localparam logic [MulPhaseW-1:0] MUL_LH  = 2'd1;
  localparam logic [MulPhaseW-1:0] MUL_HL  = 2'd2;
  localparam logic [MulPhaseW-1:0] MUL_SUM = 2'd3;

  localparam word_t SmGamma = 64'h9E37_79B9_7F4A_7C15;
  localparam word_t SmMul1  = 64'hBF58_476D_1CE4_E5B9;
  localparam word_t SmMul2  = 64'h94D0_49BB_1331_11EB;

  localparam int unsigned SmShift1 = 30;
  localparam int unsigned SmShift2 = 27;
  localparam int unsigned SmShift3 = 31;
  localparam int unsigned ShiftT   = 17;
  localparam int unsigned RotOut   = 23;
  localparam int unsigned RotS3    = 45;

  // Bit i*64+b is bit b of polynomial word i.
  localparam logic [JumpSteps-1:0] JumpPoly = {
    64'h39AB_DC45_29B1_661C, 64'hA958_2618_E03F_C9AA,
    64'hD5A6_1266_F0C9_392C, 64'h180E_C6D3_3CFD_0ABA
  };
  localparam logic [JumpSteps-1:0] LongJumpPoly = {
    64'h3910_9BB0_2ACB_E635, 64'h7771_0069_854E_E241,
    64'hC500_4E44_1C52_2FB3, 64'h76E1_5D3E_FEFD_CBBF
  };

  function automatic word_t rotl(word_t x, int unsigned k);
    return (x << k) | (x >> (WordW - k));
  endfunction

  function automatic word_t out_word(gen_state_t s);
    return rotl(s[0] + s[3], RotOut) + s[0];
  endfunction

  function automatic gen_state_t advance(gen_state_t s);
    gen_state_t n;
    word_t      t;
    t    = s[1] << ShiftT;
    n    = s;
    n[2] = s[2] ^ s[0];
    n[3] = s[3] ^ s[1];
    n[1] = s[1] ^ n[2];
    n[0] = s[0] ^ n[3];
    n[2] = n[2] ^ t;
    n[3] = rotl(n[3], RotS3);
    return n;
  endfunction

  // Controller to datapath commands.
  typedef struct packed {
    logic                 next_step;
    logic                 seed_load;
    logic                 sm_add;
    logic                 mul_en;
    logic [MulPhaseW-1:0] mul_phase;
    logic                 mul_c2;
    logic                 sm_mix;
    logic                 sm_write;
    logic [WordIdxW-1:0]  word_idx;
    logic                 jump_clear;
    logic                 jump_step;
    logic                 jump_long;
    logic [StepW-1:0]     jump_bit;
    logic                 jump_commit;
  } dp_cmd_t;

  // Datapath to controller status.
  typedef struct packed {
    logic out_free;
  } dp_status_t;

endpackage

// ----- hw/rtl/xoshpp_req_if.sv -----
// Request channel: operation and seed, valid/ready handshake.
// Depends on xoshpp_pkg.
interface xoshpp_req_if import xoshpp_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [OpW-1:0]    operation;
  logic [WordW-1:0]  seed_value;

  modport source (output valid, output operation, output seed_value, input ready);
  modport sink   (input valid, input operation, input seed_value, output ready);
endinterface

// ----- hw/rtl/xoshpp_rsp_if.sv -----
// Response channel: one random word per beat, valid/ready handshake.
// Depends on xoshpp_pkg.
interface xoshpp_rsp_if import xoshpp_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [WordW-1:0]  random_word;

  modport source (output valid, output random_word, input ready);
  modport sink   (input valid, input random_word, output ready);
endinterface

// ----- hw/rtl/xoshiro256pp_generator_core.sv -----
// Top level of the xoshiro256++ generator: request and response channels,
// controller and datapath. Depends on xoshpp_pkg, the interfaces and submodules.
//
//   channel | dir | beat payload                        | handshake
//   --------+-----+-------------------------------------+------------
//   req_i   | in  | operation[1:0], seed_value[63:0]    | valid/ready
//   rsp_o   | out | random_word[63:0] (next only)       | valid/ready
//
// Next: the step runs on the accept edge and the word sits in an output register,
//   so a new next beat is taken while that word is being taken.
// Seed: four SplitMix64 words, each built with the single shared 32x32
//   multiplier (two 64-bit products per word).
// Jump / long jump: one generator step per cycle plus a final state load.
//   Requests are held off while a seed or jump runs.
// Reset clears the four state words at once (no clearing pass); seed before use.
// A stalled rsp_o holds the word and blocks the next request until taken.

module xoshiro256pp_generator_core import xoshpp_pkg::*; (
  input  logic          clk_i,
  input  logic          rst_ni,
  xoshpp_req_if.sink    req_i,
  xoshpp_rsp_if.source  rsp_o
);

  dp_cmd_t    cmd;
  dp_status_t status;

  xoshpp_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_valid_i (req_i.valid),
    .req_op_i    (req_i.operation),
    .req_ready_o (req_i.ready),
    .status_i    (status),
    .cmd_o       (cmd)
  );

  xoshpp_datapath u_datapath (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_i        (cmd),
    .seed_value_i (req_i.seed_value),
    .out_ready_i  (rsp_o.ready),
    .out_valid_o  (rsp_o.valid),
    .out_word_o   (rsp_o.random_word),
    .status_o     (status)
  );

endmodule

// ----- hw/rtl/xoshpp_datapath.sv -----
// Generator state, SplitMix64 seeding datapath, jump accumulator, output register.
// Depends on xoshpp_pkg and the assertion macro header.
`include "xoshiro256pp_generator_core_defines.svh"

module xoshpp_datapath import xoshpp_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  dp_cmd_t     cmd_i,
  input  word_t       seed_value_i,
  input  logic        out_ready_i,
  output logic        out_valid_o,
  output word_t       out_word_o,
  output dp_status_t  status_o
);

  gen_state_t s_q, s_d;
  gen_state_t jacc_q;
  word_t      acc_q, z_q, mul_q, prod_q, word_q;
  logic       out_valid_q;

  word_t sm_sum, mul_full, mul_const, mixed_word;
  half_t mul_a, mul_b;
  logic  poly_bit;

  assign sm_sum     = acc_q + SmGamma;
  assign mul_const  = cmd_i.mul_c2 ? SmMul2 : SmMul1;
  assign mul_a      = (cmd_i.mul_phase == MUL_HL) ? z_q[WordW-1:HalfW] : z_q[HalfW-1:0];
  assign mul_b      = (cmd_i.mul_phase == MUL_LH) ? mul_const[WordW-1:HalfW]
                                                  : mul_const[HalfW-1:0];
  // upper halves are zero: a 32x32 multiplier with a full 64-bit product
  assign mul_full   = {{HalfW{1'b0}}, mul_a} * {{HalfW{1'b0}}, mul_b};
  assign mixed_word = prod_q ^ (prod_q >> SmShift3);
  assign poly_bit   = cmd_i.jump_long ? LongJumpPoly[cmd_i.jump_bit]
                                      : JumpPoly[cmd_i.jump_bit];

  always_comb begin
    s_d = s_q;
    if (cmd_i.next_step || cmd_i.jump_step) begin
      s_d = advance(s_q);
    end else if (cmd_i.sm_write) begin
      s_d[cmd_i.word_idx] = mixed_word;
    end else if (cmd_i.jump_commit) begin
      s_d = jacc_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s_q         <= '0;
      out_valid_q <= 1'b0;
    end else begin
      s_q <= s_d;
      if (cmd_i.next_step) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.next_step) begin
      word_q <= out_word(s_q);
    end
    if (cmd_i.seed_load) begin
      acc_q <= seed_value_i;
    end else if (cmd_i.sm_add) begin
      acc_q <= sm_sum;
    end
    if (cmd_i.sm_add) begin
      z_q <= sm_sum ^ (sm_sum >> SmShift1);
    end else if (cmd_i.sm_mix) begin
      z_q <= prod_q ^ (prod_q >> SmShift2);
    end
    // Low 64 bits of z*c: lo*lo + ((lo*hi + hi*lo) << 32).
    if (cmd_i.mul_en) begin
      mul_q <= mul_full;
      case (cmd_i.mul_phase)
        MUL_LH:  prod_q <= mul_q;
        MUL_HL,
        MUL_SUM: prod_q <= prod_q + {mul_q[HalfW-1:0], {HalfW{1'b0}}};
        default: prod_q <= prod_q;
      endcase
    end
    if (cmd_i.jump_clear) begin
      jacc_q <= '0;
    end else if (cmd_i.jump_step && poly_bit) begin
      jacc_q <= jacc_q ^ s_q;
    end
  end

  assign out_valid_o       = out_valid_q;
  assign out_word_o        = word_q;
  assign status_o.out_free = !out_valid_q || out_ready_i;

  `XOSHPP_ASSERT(a_next_sets_valid, clk_i, rst_ni, cmd_i.next_step |=> out_valid_q)
  `XOSHPP_ASSERT(a_mul_order, clk_i, rst_ni,
    (cmd_i.mul_en && cmd_i.mul_phase == MUL_LH) |->
      ($past(cmd_i.mul_en) && $past(cmd_i.mul_phase) == MUL_LL))
  `XOSHPP_ASSERT_NEVER(a_commit_vs_step, clk_i, rst_ni,
    cmd_i.jump_commit && (cmd_i.jump_step || cmd_i.next_step))

endmodule

// ----- hw/rtl/xoshpp_ctrl.sv -----
// Sequencer for seed and jump operations and request handshake control.
// Depends on xoshpp_pkg and the assertion macro header.
`include "xoshiro256pp_generator_core_defines.svh"

module xoshpp_ctrl import xoshpp_pkg::*; (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            req_valid_i,
  input  logic [OpW-1:0]  req_op_i,
  output logic            req_ready_o,
  input  dp_status_t      status_i,
  output dp_cmd_t         cmd_o
);

  typedef enum logic [7:0] {
    ST_IDLE   = 8'b0000_0001,
    ST_ADD    = 8'b0000_0010,
    ST_MUL1   = 8'b0000_0100,
    ST_MIX    = 8'b0000_1000,
    ST_MUL2   = 8'b0001_0000,
    ST_WRITE  = 8'b0010_0000,
    ST_JUMP   = 8'b0100_0000,
    ST_COMMIT = 8'b1000_0000
  } ctrl_state_e;

  ctrl_state_e          state_q, state_d;
  logic [WordIdxW-1:0]  word_idx_q, word_idx_d;
  logic [MulPhaseW-1:0] phase_q, phase_d;
  logic [StepW-1:0]     step_q, step_d;
  logic                 long_q, long_d;
  logic                 accept;
  logic                 is_jump;

  assign req_ready_o = (state_q == ST_IDLE) && status_i.out_free;
  assign accept      = req_valid_i && req_ready_o;
  assign is_jump     = (req_op_i == OP_JUMP) || (req_op_i == OP_LONG_JUMP);

  always_comb begin
    state_d    = state_q;
    word_idx_d = word_idx_q;
    phase_d    = phase_q;
    step_d     = step_q;
    long_d     = long_q;
    cmd_o      = '0;
    cmd_o.mul_phase = phase_q;
    cmd_o.word_idx  = word_idx_q;
    cmd_o.jump_bit  = step_q;
    cmd_o.jump_long = long_q;
    case (state_q)
      ST_IDLE: begin
        if (accept) begin
          case (req_op_i)
            OP_SEED: begin
              cmd_o.seed_load = 1'b1;
              word_idx_d      = '0;
              phase_d         = MUL_LL;
              state_d         = ST_ADD;
            end
            OP_NEXT: begin
              cmd_o.next_step = 1'b1;
            end
            default: begin
              cmd_o.jump_clear = 1'b1;
              long_d           = (req_op_i == OP_LONG_JUMP);
              step_d           = '0;
              state_d          = ST_JUMP;
            end
          endcase
        end
      end
      ST_ADD: begin
        cmd_o.sm_add = 1'b1;
        state_d      = ST_MUL1;
      end
      ST_MUL1: begin
        cmd_o.mul_en = 1'b1;
        phase_d      = phase_q + 1'b1;
        if (phase_q == MUL_SUM) begin
          state_d = ST_MIX;
        end
      end
      ST_MIX: begin
        cmd_o.sm_mix = 1'b1;
        state_d      = ST_MUL2;
      end
      ST_MUL2: begin
        cmd_o.mul_en = 1'b1;
        cmd_o.mul_c2 = 1'b1;
        phase_d      = phase_q + 1'b1;
        if (phase_q == MUL_SUM) begin
          state_d = ST_WRITE;
        end
      end
      ST_WRITE: begin
        cmd_o.sm_write = 1'b1;
        word_idx_d     = word_idx_q + 1'b1;
        state_d        = (word_idx_q == WordIdxW'(NumWords - 1)) ? ST_IDLE : ST_ADD;
      end
      ST_JUMP: begin
        cmd_o.jump_step = 1'b1;
        step_d          = step_q + 1'b1;
        if (step_q == StepW'(JumpSteps - 1)) begin
          state_d = ST_COMMIT;
        end
      end
      ST_COMMIT: begin
        cmd_o.jump_commit = 1'b1;
        state_d           = ST_IDLE;
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= ST_IDLE;
      word_idx_q <= '0;
      phase_q    <= MUL_LL;
      step_q     <= '0;
      long_q     <= 1'b0;
    end else begin
      state_q    <= state_d;
      word_idx_q <= word_idx_d;
      phase_q    <= phase_d;
      step_q     <= step_d;
      long_q     <= long_d;
    end
  end

  `XOSHPP_ASSERT(a_jump_starts, clk_i, rst_ni, (accept && is_jump) |=> (state_q == ST_JUMP))
  `XOSHPP_ASSERT(a_commit_after_jump, clk_i, rst_ni,
    (state_q == ST_COMMIT) |-> ($past(state_q) == ST_JUMP && $past(step_q) == StepW'(JumpSteps - 1)))
  `XOSHPP_ASSERT(a_next_has_room, clk_i, rst_ni, cmd_o.next_step |-> status_i.out_free)

endmodule

// ----- tb/sv/tb.sv -----
// Self-checking testbench for xoshiro256pp_generator_core: seed, next and jumps.
// Depends on xoshpp_pkg, xoshpp_req_if, xoshpp_rsp_if and the core RTL.
module tb import xoshpp_pkg::*; ();

  // SplitMix64 constants used to expand a seed into the four state words
  localparam word_t MixGamma = 64'h9E37_79B9_7F4A_7C15;
  localparam word_t MixMul1  = 64'hBF58_476D_1CE4_E5B9;
  localparam word_t MixMul2  = 64'h94D0_49BB_1331_11EB;

  // jump taps, bit i*64+b = bit b of tap word i
  localparam logic [255:0] JumpTaps = {
    64'h39AB_DC45_29B1_661C, 64'hA958_2618_E03F_C9AA,
    64'hD5A6_1266_F0C9_392C, 64'h180E_C6D3_3CFD_0ABA
  };
  localparam logic [255:0] LongJumpTaps = {
    64'h3910_9BB0_2ACB_E635, 64'h7771_0069_854E_E241,
    64'hC500_4E44_1C52_2FB3, 64'h76E1_5D3E_FEFD_CBBF
  };

  localparam int CycleLimit  = 1_000_000;
  localparam int TailCycles  = 300;   // covers a jump still running at the end
  localparam int HoldCycles  = 300;   // long receiver hold-off
  localparam int PhaseBeats  = 250;
  localparam int PressBeats  = 50;
  localparam int MaxPrinted  = 200;

  typedef struct {
    xoshpp_op_e op;
    word_t      seed;
    bit         pinned;   // expected word typed in below
    word_t      word;
  } stim_row_t;

  logic clk_i  = 1'b0;
  logic rst_ni = 1'b0;

  xoshpp_req_if req_if ();
  xoshpp_rsp_if rsp_if ();

  xoshiro256pp_generator_core i_dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (req_if),
    .rsp_o  (rsp_if)
  );

  always #1 clk_i = ~clk_i;

  // predicted generator state and the words still owed by the core
  word_t gen_w [NumWords];
  word_t exp_words [$];

  int err_cnt       = 0;
  int cycle_cnt     = 0;
  int send_idle_pct = 0;
  int rsp_stall_pct = 0;
  int hold_req      = 0;

  // Directed part. Only words that follow from an all-zero state are pinned;
  // everything else goes through the predictor.
  stim_row_t dir_rows [24] = '{
    '{OP_NEXT,      64'h0,                   1'b1, 64'h0},  // unseeded: zero
    '{OP_JUMP,      64'hFFFF_FFFF_FFFF_FFFF, 1'b0, 64'h0},  // zero stays zero
    '{OP_LONG_JUMP, 64'hFFFF_FFFF_FFFF_FFFF, 1'b0, 64'h0},
    '{OP_NEXT,      64'hFFFF_FFFF_FFFF_FFFF, 1'b1, 64'h0},
    '{OP_SEED,      64'h0,                   1'b0, 64'h0},
    '{OP_NEXT,      64'h0,                   1'b0, 64'h0},
    '{OP_NEXT,      64'h0,                   1'b0, 64'h0},
    '{OP_JUMP,      64'h0,                   1'b0, 64'h0},
    '{OP_NEXT,      64'h0,                   1'b0, 64'h0},
    '{OP_LONG_JUMP, 64'h0,                   1'b0, 64'h0},
    '{OP_NEXT,      64'h0,                   1'b0, 64'h0},
    '{OP_SEED,      64'hFFFF_FFFF_FFFF_FFFF, 1'b0, 64'h0},
    '{OP_NEXT,      64'h0,                   1'b0, 64'h0},
    '{OP_NEXT,      64'h5555_5555_5555_5555, 1'b0, 64'h0},  // seed field ignored
    '{OP_SEED,      64'h8000_0000_0000_0000, 1'b0, 64'h0},
    '{OP_NEXT,      64'hAAAA_AAAA_AAAA_AAAA, 1'b0, 64'h0},
    '{OP_SEED,      64'h1,                   1'b0, 64'h0},
    '{OP_NEXT,      64'h0,                   1'b0, 64'h0},
    '{OP_JUMP,      64'h1234_5678_9ABC_DEF0, 1'b0, 64'h0},
    '{OP_JUMP,      64'h0,                   1'b0, 64'h0},
    '{OP_NEXT,      64'h0,                   1'b0, 64'h0},
    '{OP_LONG_JUMP, 64'h0,                   1'b0, 64'h0},
    '{OP_NEXT,      64'h0,                   1'b0, 64'h0},
    '{OP_NEXT,      64'hFFFF_FFFF_FFFF_FFFF, 1'b0, 64'h0}
  };

  // ---------------------------------------------------------------- predictor

  function automatic word_t rot_left(word_t v, int unsigned n);
    logic [2*WordW-1:0] dbl;
    dbl = {v, v} >> (WordW - n);
    return dbl[WordW-1:0];
  endfunction

  // four SplitMix64 outputs of the seed, in order
  function automatic void seed_state(word_t seed);
    word_t acc;
    word_t z;
    acc = seed;
    for (int k = 0; k < NumWords; k++) begin
      acc = acc + MixGamma;
      z = acc;
      z = (z ^ (z >> 30)) * MixMul1;
      z = (z ^ (z >> 27)) * MixMul2;
      gen_w[k] = z ^ (z >> 31);
    end
  endfunction

  // output word from the current state, then one generator step
  function automatic word_t gen_step();
    word_t res;
    word_t t;
    res = rot_left(gen_w[0] + gen_w[3], 23) + gen_w[0];
    t = gen_w[1] << 17;
    gen_w[2] = gen_w[2] ^ gen_w[0];
    gen_w[3] = gen_w[3] ^ gen_w[1];
    gen_w[1] = gen_w[1] ^ gen_w[2];
    gen_w[0] = gen_w[0] ^ gen_w[3];
    gen_w[2] = gen_w[2] ^ t;
    gen_w[3] = rot_left(gen_w[3], 45);
    return res;
  endfunction

  // 256 steps, XOR-collecting the states picked by the taps
  function automatic void jump_state(logic [255:0] taps);
    word_t acc [NumWords];
    foreach (acc[k]) acc[k] = '0;
    for (int b = 0; b < 256; b++) begin
      if (taps[b]) begin
        for (int k = 0; k < NumWords; k++) acc[k] = acc[k] ^ gen_w[k];
      end
      void'(gen_step());
    end
    gen_w = acc;
  endfunction

  // ---------------------------------------------------------------- request side

  // Offer one beat, with random idle cycles in front of it, and update the
  // prediction on the edge that takes it. valid gets one NBA per edge only.
  task automatic send_beat(xoshpp_op_e op, word_t seed, bit pinned, word_t word);
    word_t w;
    while ($urandom_range(99) < send_idle_pct) begin
      req_if.valid <= 1'b0;
      @(posedge clk_i);
    end
    req_if.valid      <= 1'b1;
    req_if.operation  <= op;
    req_if.seed_value <= seed;
    @(posedge clk_i);
    while (!req_if.ready) @(posedge clk_i);
    case (op)
      OP_SEED: seed_state(seed);
      OP_NEXT: begin
        w = gen_step();
        exp_words.push_back(pinned ? word : w);
      end
      OP_JUMP: jump_state(JumpTaps);
      default: jump_state(LongJumpTaps);
    endcase
  endtask

  // Mostly next beats; seeds and jumps are rare since they hold off requests until done.
  task automatic random_beat();
    int    pick;
    word_t seed;
    xoshpp_op_e op;
    pick = $urandom_range(99);
    if (pick < 84)      op = OP_NEXT;
    else if (pick < 92) op = OP_SEED;
    else if (pick < 96) op = OP_JUMP;
    else                op = OP_LONG_JUMP;
    case ($urandom_range(15))
      0:       seed = '0;
      1:       seed = '1;
      2:       seed = word_t'(1) << $urandom_range(WordW-1);
      default: seed = {$urandom, $urandom};
    endcase
    send_beat(op, seed, 1'b0, '0);
  endtask

  // sender pauses until every owed word has come back; at least one edge
  // passes so the idle valid lands before the next beat is offered
  task automatic wait_drained();
    req_if.valid <= 1'b0;
    @(posedge clk_i);
    while (exp_words.size() != 0) @(posedge clk_i);
  endtask

  // ---------------------------------------------------------------- response side

  task automatic report_err(string what, word_t got, word_t want);
    if (err_cnt < MaxPrinted)
      $display("tb: cycle %0d: %s: got %h want %h", cycle_cnt, what, got, want);
    err_cnt++;
  endtask

  // ready pattern; a bump of hold_req starts a long hold-off counted here
  initial begin : rsp_ready_drv
    int hold_left;
    int hold_seen;
    hold_left = 0;
    hold_seen = 0;
    rsp_if.ready <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (hold_seen != hold_req) begin
        hold_seen = hold_req;
        hold_left = HoldCycles;
      end
      if (hold_left > 0) begin
        hold_left--;
        rsp_if.ready <= 1'b0;
      end else begin
        rsp_if.ready <= ($urandom_range(99) >= rsp_stall_pct);
      end
    end
  end

  // compare every taken word with the oldest owed word
  always @(posedge clk_i) begin : word_check
    word_t want;
    if (rst_ni && rsp_if.valid === 1'b1 && rsp_if.ready) begin
      if (exp_words.size() == 0) begin
        report_err("word with none owed", rsp_if.random_word, '0);
      end else begin
        want = exp_words.pop_front();
        if (rsp_if.random_word !== want) report_err("random_word", rsp_if.random_word, want);
      end
    end
  end

  // watchdog
  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt == CycleLimit) begin
      $display("tb: done, errors");
      $finish;
    end
  end

  // ---------------------------------------------------------------- sequence

  initial begin : stimulus
    int stall_tab [4][2];
    stall_tab = '{'{0, 0}, '{81, 0}, '{0, 81}, '{16, 16}};
    req_if.valid      <= 1'b0;
    req_if.operation  <= OP_SEED;
    req_if.seed_value <= '0;
    foreach (gen_w[k]) gen_w[k] = '0;   // reset state of the core
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed rows, no idling
    foreach (dir_rows[i])
      send_beat(dir_rows[i].op, dir_rows[i].seed, dir_rows[i].pinned, dir_rows[i].word);
    wait_drained();

    // back-pressure: receiver holds off while next beats keep coming, so the
    // output register fills and the core stops taking requests
    hold_req++;
    for (int i = 0; i < PressBeats; i++) send_beat(OP_NEXT, {$urandom, $urandom}, 1'b0, '0);
    wait_drained();

    // random phases: free flow, sender idle, receiver stalling, both
    foreach (stall_tab[p]) begin
      send_idle_pct = stall_tab[p][0];
      rsp_stall_pct = stall_tab[p][1];
      for (int i = 0; i < PhaseBeats; i++) random_beat();
      wait_drained();
    end

    // last beat may have been a jump; give the core time to show stray words
    repeat (TailCycles) @(posedge clk_i);
    if (err_cnt == 0) begin
      $display("tb: done, clean");
    end else begin
      $display("tb: done, errors");
    end
    $finish;
  end

endmodule

// ----- files.f -----
+incdir+hw/rtl
hw/rtl/xoshpp_pkg.sv
hw/rtl/xoshpp_req_if.sv
hw/rtl/xoshpp_rsp_if.sv
hw/rtl/xoshpp_datapath.sv
hw/rtl/xoshpp_ctrl.sv
hw/rtl/xoshiro256pp_generator_core.sv
tb/sv/tb.sv
